[hw/rtl/vmmu_pkg.sv]
// shared types, constants and saturation helper for the vector matrix unit
package vmmu_pkg;

   typedef enum logic [3:0] {
      ACT_LOAD   = 4'd0,
      ACT_ADD    = 4'd1,
      ACT_SUB    = 4'd2,
      ACT_CROSS  = 4'd3,
      ACT_SCALE  = 4'd4,
      ACT_DIV    = 4'd5,
      ACT_DOT    = 4'd6,
      ACT_MAG    = 4'd7,
      ACT_NORM   = 4'd8,
      ACT_MATVEC = 4'd9,
      ACT_XY     = 4'd10,
      ACT_XCOL   = 4'd11,
      ACT_YCOL   = 4'd12,
      ACT_YRAW   = 4'd13,
      ACT_ZCOL   = 4'd14
   } action_type;

   localparam int LANES       = 3;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 48;

   localparam logic signed [31:0] ONE_Q   = 32'sh0001_0000;
   localparam logic        [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic        [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic en1;
      logic en2;
      logic neg1;
   } lane_ctl_type;

   typedef struct packed {
      logic [31:0] val;
      logic        ov;
   } sat_type;

   function automatic sat_type sat32(input logic signed [67:0] v);
      sat_type r;
      r.ov  = !((&v[67:31]) || (~|v[67:31]));
      r.val = r.ov ? (v[67] ? SAT_MIN : SAT_MAX) : v[31:0];
      return r;
   endfunction

endpackage

[hw/rtl/vmmu_mul_lane.sv]
// one lane: three signed products, then their sum
module vmmu_mul_lane
   import vmmu_pkg::*;
(
   input  logic                clock,
   input  logic                adv,
   input  logic signed [31:0]  x0,
   input  logic signed [31:0]  y0,
   input  logic signed [31:0]  x1,
   input  logic signed [31:0]  y1,
   input  logic signed [31:0]  x2,
   input  logic signed [31:0]  y2,
   input  lane_ctl_type        ctl,
   output logic signed [65:0]  sum
);

   logic signed [63:0] p0_ff, p1_ff, p2_ff;
   logic signed [63:0] p0_in, p1_in, p2_in;
   lane_ctl_type       ctl_ff;
   logic signed [65:0] sum_ff, sum_in;
   logic signed [65:0] t1, t2;

   assign p0_in = x0 * y0;
   assign p1_in = x1 * y1;
   assign p2_in = x2 * y2;

   always_comb begin
      t1 = 66'sd0;
      t2 = 66'sd0;
      if (ctl_ff.en1) begin
         t1 = ctl_ff.neg1 ? -66'(p1_ff) : 66'(p1_ff);
      end
      if (ctl_ff.en2) begin
         t2 = 66'(p2_ff);
      end
      sum_in = 66'(p0_ff) + t1 + t2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         ctl_ff <= ctl;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

[hw/rtl/vmmu_sqrt.sv]
// pipelined floor square root, two radicand bits per stage
module vmmu_sqrt
   import vmmu_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] n,
   output logic [31:0] root
);

   logic [33:0] rem_ff  [SQRT_STAGES];
   logic [31:0] root_ff [SQRT_STAGES];
   logic [63:0] rad_ff  [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [33:0] rem_prev;
      logic [31:0] root_prev;
      logic [63:0] rad_prev;
      logic [35:0] remx;
      logic [35:0] trial;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = n;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      assign remx  = {rem_prev, rad_prev[63:62]};
      assign trial = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (adv) begin
            if (remx >= trial) begin
               rem_ff[k]  <= 34'(remx - trial);
               root_ff[k] <= {root_prev[30:0], 1'b1};
            end else begin
               rem_ff[k]  <= remx[33:0];
               root_ff[k] <= {root_prev[30:0], 1'b0};
            end
            rad_ff[k] <= {rad_prev[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

[hw/rtl/vmmu_div_lane.sv]
// pipelined restoring divider, one quotient bit per stage
module vmmu_div_lane
   import vmmu_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  logic [47:0] num,
   input  logic [31:0] den,
   output logic [47:0] quo
);

   logic [31:0] rem_ff [DIV_STAGES];
   logic [47:0] nq_ff  [DIV_STAGES];
   logic [31:0] d_ff   [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem_prev;
      logic [47:0] nq_prev;
      logic [31:0] d_prev;
      logic [32:0] remx;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign d_prev   = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign d_prev   = d_ff[k-1];
      end

      assign remx = {rem_prev, nq_prev[47]};
      assign ge   = remx >= {1'b0, d_prev};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? 32'(remx - {1'b0, d_prev}) : remx[31:0];
            nq_ff[k]  <= {nq_prev[46:0], ge};
            d_ff[k]   <= d_prev;
         end
      end
   end

   assign quo = nq_ff[DIV_STAGES-1];

endmodule

[hw/rtl/vector3_matrix_math_unit.sv]
// top level: Q16.16 vector and matrix unit with product lanes, sqrt and dividers
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | action, a, b, scalar, row index
//   rsp     | out       | rsp_valid / rsp_stall  | rx, ry, rz, scalar_out, overflow
//
// one item per cycle unless a stalled output freezes the pipe; each item passes from accept to the
// output register through three product and merge stages, the 32-stage square root and the 48-stage divider
// every action runs through the same pipe, so results leave in order
// synchronous reset clears valid bits, the output valid flag and the stored matrix
// a stalled output freezes the pipe only once its last stage holds an item
module vector3_matrix_math_unit
   import vmmu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_action,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_az,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_bz,
   input  logic signed [31:0] req_scalar_in,
   input  logic [1:0]         req_row_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rx,
   output logic signed [31:0] rsp_ry,
   output logic signed [31:0] rsp_rz,
   output logic signed [31:0] rsp_scalar_out,
   output logic               rsp_overflow
);

   localparam int DEPTH = 3 + SQRT_STAGES + DIV_STAGES;

   typedef struct packed {
      action_type         act;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] s;
   } front_type;

   typedef struct packed {
      action_type         act;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] s;
      logic [31:0]        rx;
      logic [31:0]        ry;
      logic [31:0]        rz;
      logic [31:0]        sc;
      logic               ov;
   } back_type;

   typedef struct packed {
      action_type  act;
      logic [31:0] rx;
      logic [31:0] ry;
      logic [31:0] rz;
      logic [31:0] sc;
      logic        ov;
      logic [2:0]  neg;
   } tail_type;

   // handshake and valid line
   logic             adv;
   logic             accept;
   logic             v_ff [DEPTH];
   logic             v_last;
   action_type       act_in;
   logic signed [31:0] a_v [LANES];
   logic signed [31:0] b_v [LANES];

   // matrix store
   logic signed [31:0] m_ff [9];

   // front stages
   front_type          f_in, f1_ff, f2_ff, f3_ff;
   logic signed [65:0] lane_sum [LANES];
   logic [31:0]        r3_ff [LANES];
   logic [31:0]        r3_in [LANES];
   logic [LANES-1:0]   ov3_lane;
   logic               ov3_ff;
   logic               lane_op;
   logic signed [67:0] tot3_ff, tot3_in;

   // sqrt section
   back_type           b_in;
   back_type           sq_ff [SQRT_STAGES];
   back_type           bq;
   sat_type            dot_sat;
   logic [31:0]        root;

   // divider section
   sat_type            mag_sat;
   logic [31:0]        s_abs, den;
   logic signed [31:0] av_q [LANES];
   logic [31:0]        a_abs [LANES];
   logic [47:0]        quo [LANES];
   tail_type           t_in;
   tail_type           dv_ff [DIV_STAGES];
   tail_type           tl;
   sat_type            dsat [LANES];
   logic               is_div;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rx_ff, ry_ff, rz_ff, sc_ff;
   logic [31:0]        rx_in, ry_in, rz_in, sc_in;
   logic               ov_ff, ov_in;

   assign v_last    = v_ff[DEPTH-1];
   assign adv       = !v_last || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign act_in    = action_type'(req_action);

   assign a_v[0] = req_ax;
   assign a_v[1] = req_ay;
   assign a_v[2] = req_az;
   assign b_v[0] = req_bx;
   assign b_v[1] = req_by;
   assign b_v[2] = req_bz;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int k = 1; k < DEPTH; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // matrix rows written by load row
   for (genvar k = 0; k < 9; k++) begin : g_mat
      localparam int R = k / 3;
      localparam int C = k % 3;
      always_ff @(posedge clock) begin
         if (reset) begin
            m_ff[k] <= '0;
         end else if (accept && act_in == ACT_LOAD && req_row_index == 2'(R)) begin
            m_ff[k] <= a_v[C];
         end
      end
   end

   // operand select per lane
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int P = (i + 1) % 3;
      localparam int Q = (i + 2) % 3;
      logic signed [31:0] x0, y0, x1, y1, x2, y2;
      lane_ctl_type       ctl;

      always_comb begin
         x0  = a_v[i];
         y0  = ONE_Q;
         x1  = b_v[i];
         y1  = ONE_Q;
         x2  = '0;
         y2  = '0;
         ctl = '0;
         unique case (act_in) inside
            ACT_ADD: begin
               ctl.en1 = 1'b1;
            end
            ACT_SUB: begin
               ctl.en1  = 1'b1;
               ctl.neg1 = 1'b1;
            end
            ACT_CROSS: begin
               x0       = a_v[P];
               y0       = b_v[Q];
               x1       = b_v[P];
               y1       = a_v[Q];
               ctl.en1  = 1'b1;
               ctl.neg1 = 1'b1;
            end
            ACT_SCALE: begin
               y0 = req_scalar_in;
            end
            ACT_DOT: begin
               y0 = b_v[i];
            end
            ACT_MAG, ACT_NORM: begin
               y0 = a_v[i];
            end
            ACT_MATVEC, ACT_XY: begin
               x0      = m_ff[i*3];
               y0      = a_v[0];
               x1      = m_ff[i*3+1];
               y1      = a_v[1];
               x2      = m_ff[i*3+2];
               y2      = a_v[2];
               ctl.en1 = 1'b1;
               ctl.en2 = (act_in == ACT_MATVEC);
            end
            ACT_XCOL: begin
               x0 = m_ff[i*3];
               y0 = a_v[0];
            end
            ACT_YCOL: begin
               x0 = m_ff[i*3+1];
               y0 = a_v[1];
            end
            ACT_YRAW: begin
               x0 = m_ff[i*3+1];
            end
            ACT_ZCOL: begin
               x0 = m_ff[i*3+2];
               y0 = a_v[2];
            end
            default: ;
         endcase
      end

      vmmu_mul_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .x0    (x0),
         .y0    (y0),
         .x1    (x1),
         .y1    (y1),
         .x2    (x2),
         .y2    (y2),
         .ctl   (ctl),
         .sum   (lane_sum[i])
      );
   end

   // sideband for the product stages
   always_comb begin
      f_in.act = act_in;
      f_in.ax  = req_ax;
      f_in.ay  = req_ay;
      f_in.az  = req_az;
      f_in.s   = req_scalar_in;
   end

   always_comb begin
      case (f2_ff.act) inside
         ACT_ADD, ACT_SUB, ACT_CROSS, ACT_SCALE, ACT_MATVEC, ACT_XY, ACT_XCOL,
         ACT_YCOL, ACT_YRAW, ACT_ZCOL: lane_op = 1'b1;
         default:                     lane_op = 1'b0;
      endcase
   end

   // merge: lane results and the cross-lane sum for dot and magnitude
   for (genvar i = 0; i < LANES; i++) begin : g_merge
      sat_type ls;
      assign ls          = sat32(68'(lane_sum[i] >>> 16));
      assign r3_in[i]    = lane_op ? ls.val : '0;
      assign ov3_lane[i] = lane_op && ls.ov;
   end

   assign tot3_in = 68'(lane_sum[0]) + 68'(lane_sum[1]) + 68'(lane_sum[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff   <= f_in;
         f2_ff   <= f1_ff;
         f3_ff   <= f2_ff;
         r3_ff   <= r3_in;
         ov3_ff  <= |ov3_lane;
         tot3_ff <= tot3_in;
      end
   end

   // dot result and sideband into the sqrt section
   assign dot_sat = sat32(tot3_ff >>> 16);

   always_comb begin
      b_in.act = f3_ff.act;
      b_in.ax  = f3_ff.ax;
      b_in.ay  = f3_ff.ay;
      b_in.az  = f3_ff.az;
      b_in.s   = f3_ff.s;
      b_in.rx  = r3_ff[0];
      b_in.ry  = r3_ff[1];
      b_in.rz  = r3_ff[2];
      b_in.sc  = (f3_ff.act == ACT_DOT) ? dot_sat.val : '0;
      b_in.ov  = ov3_ff || (f3_ff.act == ACT_DOT && dot_sat.ov);
   end

   vmmu_sqrt u_sqrt (
      .clock (clock),
      .adv   (adv),
      .n     (tot3_ff[63:0]),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0] <= b_in;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sq_ff[k] <= sq_ff[k-1];
         end
      end
   end

   // divider setup
   assign bq      = sq_ff[SQRT_STAGES-1];
   assign av_q[0] = bq.ax;
   assign av_q[1] = bq.ay;
   assign av_q[2] = bq.az;
   assign mag_sat = sat32(68'({36'd0, root}));

   always_comb begin
      s_abs = bq.s[31] ? 32'(-bq.s) : bq.s;
      den   = (bq.act == ACT_DIV) ? s_abs : root;
      if (den == '0) begin
         den = 32'd1;
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_div
      assign a_abs[i]  = av_q[i][31] ? 32'(-av_q[i]) : av_q[i];
      assign t_in.neg[i] = av_q[i][31] ^ (bq.act == ACT_DIV && bq.s[31]);

      vmmu_div_lane u_div (
         .clock (clock),
         .adv   (adv),
         .num   ({a_abs[i], 16'd0}),
         .den   (den),
         .quo   (quo[i])
      );
   end

   assign t_in.act = bq.act;
   assign t_in.rx  = bq.rx;
   assign t_in.ry  = bq.ry;
   assign t_in.rz  = bq.rz;
   assign t_in.sc  = (bq.act == ACT_MAG) ? mag_sat.val : bq.sc;
   assign t_in.ov  = bq.ov || (bq.act == ACT_MAG && mag_sat.ov);

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= t_in;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
   end

   // quotient sign and saturation
   assign tl     = dv_ff[DIV_STAGES-1];
   assign is_div = (tl.act == ACT_DIV) || (tl.act == ACT_NORM);

   for (genvar i = 0; i < LANES; i++) begin : g_quo
      logic signed [48:0] qs;
      assign qs      = tl.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      assign dsat[i] = sat32(68'(qs));
   end

   assign rx_in = is_div ? dsat[0].val : tl.rx;
   assign ry_in = is_div ? dsat[1].val : tl.ry;
   assign rz_in = is_div ? dsat[2].val : tl.rz;
   assign sc_in = tl.sc;
   assign ov_in = tl.ov || (is_div && (dsat[0].ov || dsat[1].ov || dsat[2].ov));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv && v_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v_last) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
         sc_ff <= sc_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rx         = rx_ff;
   assign rsp_ry         = ry_ff;
   assign rsp_rz         = rz_ff;
   assign rsp_scalar_out = sc_ff;
   assign rsp_overflow   = ov_ff;

   // overflow only with a saturated field
   a_ov_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ov_ff |->
         rx_ff == SAT_MAX || rx_ff == SAT_MIN || ry_ff == SAT_MAX || ry_ff == SAT_MIN ||
         rz_ff == SAT_MAX || rz_ff == SAT_MIN || sc_ff == SAT_MAX || sc_ff == SAT_MIN)
      else $error("overflow without a saturated field");

   // an empty output register never holds off the input
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled with empty output");

   // load of row zero lands in the store
   a_load_row0: assert property (@(posedge clock) disable iff (reset)
      accept && act_in == ACT_LOAD && req_row_index == 2'd0 |=>
         m_ff[0] == $past(req_ax) && m_ff[1] == $past(req_ay) && m_ff[2] == $past(req_az))
      else $error("matrix row load lost");

endmodule
